@@ rtl/lbei_pkg.sv @@
// Package for the LFSR bit error injector: lane count, frame length, LFSR
// taps, seed mixing and the types shared by the lane, output and top modules.
// No dependencies.
`timescale 1ns / 1ps

package lbei_pkg;

  localparam int unsigned LaneCount  = 4;
  localparam int unsigned FrameWords = 16;

  // Lane groups per frame, never fewer than one.
  localparam int unsigned Groups = (FrameWords / LaneCount == 0) ? 1 : FrameWords / LaneCount;
  localparam int unsigned PosW   = (Groups > 1) ? $clog2(Groups) : 1;

  localparam int unsigned WordW    = 32;
  localparam int unsigned LaneW    = WordW + 1;
  localparam int unsigned ItemW    = LaneCount * LaneW;
  localparam int unsigned TdataW   = ((ItemW + 7) / 8) * 8;

  localparam logic [WordW-1:0] LfsrTaps  = 32'hd000_0001;
  localparam logic [WordW-1:0] LaneMix   = 32'h9E37_79B9;
  localparam logic [WordW-1:0] SeedReset = 32'd19660809;

  typedef logic [PosW-1:0] pos_t;

  // Per-item control from the top level to every lane.
  typedef struct packed {
    logic step;
    logic reseed;
  } lane_ctrl_t;

  // One result as it sits in the output stage.
  typedef struct packed {
    logic              last;
    logic [ItemW-1:0]  data;
  } out_item_t;

  // Lane index times the golden-ratio constant, modulo 2^32.
  function automatic logic [WordW-1:0] lane_mix(input int unsigned lane);
    logic [63:0] prod;
    prod = 64'(lane) * 64'(LaneMix);
    return prod[WordW-1:0];
  endfunction

  // One step of the right-shifting Galois LFSR.
  function automatic logic [WordW-1:0] lfsr_step(input logic [WordW-1:0] s);
    return (s >> 1) ^ (s[0] ? LfsrTaps : '0);
  endfunction

endpackage

@@ rtl/lbei_lane.sv @@
// One lane of the error injector: holds the lane's LFSR, steps it per request
// and flips the data bit when the new value is below the threshold.
// Depends on lbei_pkg.
`timescale 1ns / 1ps

module lbei_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbei_pkg::lane_ctrl_t        ctrl_i,
  input  logic [lbei_pkg::WordW-1:0]  reseed_val_i,
  input  logic [lbei_pkg::WordW-1:0]  prob_i,
  input  logic                        bit_i,
  output logic [lbei_pkg::WordW-1:0]  word_o,
  output logic                        noisy_o
);

  logic [lbei_pkg::WordW-1:0] gen_q, gen_d;
  logic [lbei_pkg::WordW-1:0] base;

  // At a frame start the freshly mixed seed replaces the stored state.
  assign base    = ctrl_i.reseed ? reseed_val_i : gen_q;
  assign gen_d   = lbei_pkg::lfsr_step(base);
  assign word_o  = gen_d;
  assign noisy_o = bit_i ^ (gen_d < prob_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
    end else if (ctrl_i.step) begin
      gen_q <= gen_d;
    end
  end

endmodule

@@ rtl/lbei_out.sv @@
// Output stage of the error injector: merges the lane results into one
// stream item and holds it in a main register backed by a skid register.
// Depends on lbei_pkg.
`timescale 1ns / 1ps

module lbei_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  lbei_pkg::out_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lbei_pkg::out_item_t   out_item_o
);

  logic                main_valid_q, skid_valid_q;
  lbei_pkg::out_item_t main_q, skid_q;
  logic                in_fire, take;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign take        = main_valid_q && out_ready_i;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_fire;
      end
    end else if (in_fire) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (in_fire) begin
        main_q <= in_item_i;
      end
    end else if (in_fire) begin
      if (!main_valid_q) begin
        main_q <= in_item_i;
      end else begin
        skid_q <= in_item_i;
      end
    end
  end

endmodule

@@ rtl/lfsr_bit_error_injector.sv @@
// Top level of the LFSR bit error injector: seed register, frame position
// counter, the parallel lanes and the output stage.
// Depends on lbei_pkg, lbei_lane and lbei_out.
// All lanes step their LFSRs together; each result is registered in lbei_out.
// Throughput: one lane group per cycle while the skid register is empty.
// The skid register lets one more request in while a result waits downstream.
// Reset: seed returns to 19660809, frame position to zero, output stage empty.
`timescale 1ns / 1ps

module lfsr_bit_error_injector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lbei_pkg::WordW-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // Per lane from lane 0 up: flip_probability_i[31:0], data_bit_i; zero fill.
  input  logic [lbei_pkg::TdataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // Per lane from lane 0 up: random_word_i[31:0], noisy_bit_i; zero fill.
  output logic [lbei_pkg::TdataW-1:0]  m_axis_tdata,
  // last_of_frame.
  output logic                         m_axis_tlast
);

  logic [lbei_pkg::WordW-1:0] seed_q;
  lbei_pkg::pos_t             pos_q, pos_d;
  logic                       in_fire, last;
  lbei_pkg::lane_ctrl_t       ctrl;
  lbei_pkg::out_item_t        item, out_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= lbei_pkg::SeedReset;
    end else if (cfg_valid_i) begin
      seed_q <= cfg_data_i;
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign last    = (pos_q == lbei_pkg::PosW'(lbei_pkg::Groups - 1));
  assign pos_d   = last ? '0 : pos_q + lbei_pkg::PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (in_fire) begin
      pos_q <= pos_d;
    end
  end

  assign ctrl.step   = in_fire;
  assign ctrl.reseed = (pos_q == '0);

  for (genvar g = 0; g < lbei_pkg::LaneCount; g++) begin : g_lane
    lbei_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .reseed_val_i (seed_q ^ lbei_pkg::lane_mix(g)),
      .prob_i       (s_axis_tdata[g*lbei_pkg::LaneW +: lbei_pkg::WordW]),
      .bit_i        (s_axis_tdata[g*lbei_pkg::LaneW + lbei_pkg::WordW]),
      .word_o       (item.data[g*lbei_pkg::LaneW +: lbei_pkg::WordW]),
      .noisy_o      (item.data[g*lbei_pkg::LaneW + lbei_pkg::WordW])
    );
  end

  assign item.last = last;

  lbei_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata = lbei_pkg::TdataW'(out_item.data);
  assign m_axis_tlast = out_item.last;

endmodule

@@ rtl/lbei_checker.sv @@
// Port-level checker for the LFSR bit error injector, with its bind.
// Depends on lbei_pkg and the top level lfsr_bit_error_injector.
`timescale 1ns / 1ps

module lbei_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lbei_pkg::TdataW-1:0]  m_axis_tdata,
  input logic                         m_axis_tlast
);

  lbei_pkg::pos_t out_pos_q;

  // Counts delivered results within the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_pos_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (out_pos_q == lbei_pkg::PosW'(lbei_pkg::Groups - 1)) begin
        out_pos_q <= '0;
      end else begin
        out_pos_q <= out_pos_q + lbei_pkg::PosW'(1);
      end
    end
  end

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // After an accepted request the output holds a valid result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  // The input only backs off while a result is waiting.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output empty");

  // The frame flag marks every frame's final group in delivery order.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tlast == (out_pos_q == lbei_pkg::PosW'(lbei_pkg::Groups - 1))))
    else $error("frame flag out of place");

endmodule

bind lfsr_bit_error_injector lbei_checker u_lbei_checker (.*);

@@ verif/testbench.sv @@
// Self-checking testbench for lfsr_bit_error_injector: random and directed lane
// groups with seed writes, checked against a built-in lane LFSR predictor.
// Depends on lbei_pkg and the lfsr_bit_error_injector RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NumLanes = lbei_pkg::LaneCount;
  localparam int unsigned TdataW   = lbei_pkg::TdataW;
  localparam int unsigned LaneBits = 33;
  localparam int unsigned GroupsPerFrame =
      (lbei_pkg::FrameWords / NumLanes == 0) ? 1 : lbei_pkg::FrameWords / NumLanes;

  localparam logic [31:0] TapMask     = 32'hd000_0001;
  localparam logic [31:0] GoldenMix   = 32'h9E37_79B9;
  localparam logic [31:0] SeedAtReset = 32'd19660809;

  localparam int SettleCycles = 3;
  localparam int CycleLimit   = 100000;
  localparam int MaxReports   = 10;
  localparam int RandomGroups = 1000;

  typedef enum logic [1:0] {ReqGroup, ReqSeed, ReqDrain, ReqPhase} request_kind_e;

  typedef struct packed {
    request_kind_e              kind;
    logic [NumLanes-1:0][31:0]  thresh;
    logic [NumLanes-1:0]        bits;
    logic [31:0]                seed;
    logic [6:0]                 idle_pct;
    logic [6:0]                 stall_pct;
  } stim_request_t;

  typedef struct packed {
    logic [NumLanes-1:0][31:0]  word;
    logic [NumLanes-1:0]        noisy;
    logic                       last;
  } noisy_group_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [31:0]        cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TdataW-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TdataW-1:0]  m_axis_tdata;
  logic               m_axis_tlast;

  lfsr_bit_error_injector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  stim_request_t pending_requests[$];
  noisy_group_t  predicted_groups[$];

  // Predictor state: seed register, per-lane LFSRs and position in the frame.
  logic [31:0]  model_seed = SeedAtReset;
  logic [31:0]  model_lfsr [NumLanes];
  int unsigned  model_pos = 0;

  logic [6:0]   send_idle_pct = '0;
  logic [6:0]   recv_stall_pct = '0;
  logic         group_taken = 1'b0;
  logic         seed_taken = 1'b0;
  int           settle_count = 0;
  int           mismatch_count = 0;
  int           result_count = 0;
  int           cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic noisy_group_t inject_errors(input logic [TdataW-1:0] req);
    noisy_group_t res;
    logic [31:0]  s;
    logic [31:0]  lane_id;
    if (model_pos >= GroupsPerFrame) model_pos = 0;
    if (model_pos == 0) begin
      for (int l = 0; l < NumLanes; l++) begin
        lane_id = l;
        model_lfsr[l] = model_seed ^ (lane_id * GoldenMix);
      end
    end
    for (int l = 0; l < NumLanes; l++) begin
      s = model_lfsr[l];
      s = (s >> 1) ^ (s[0] ? TapMask : 32'h0);
      model_lfsr[l] = s;
      res.word[l]   = s;
      res.noisy[l]  = req[l*LaneBits+32] ^ (s < req[l*LaneBits +: 32]);
    end
    res.last = (model_pos == GroupsPerFrame - 1);
    model_pos++;
    if (model_pos >= GroupsPerFrame) model_pos = 0;
    return res;
  endfunction

  task automatic push_group(input logic [NumLanes-1:0][31:0] th,
                            input logic [NumLanes-1:0] b);
    stim_request_t r;
    r = '0;
    r.kind   = ReqGroup;
    r.thresh = th;
    r.bits   = b;
    pending_requests.push_back(r);
  endtask

  task automatic push_drain();
    stim_request_t r;
    r = '0;
    r.kind = ReqDrain;
    pending_requests.push_back(r);
  endtask

  // A seed write is only issued once the block has gone idle.
  task automatic push_seed(input logic [31:0] value);
    stim_request_t r;
    push_drain();
    r = '0;
    r.kind = ReqSeed;
    r.seed = value;
    pending_requests.push_back(r);
  endtask

  task automatic push_phase(input logic [6:0] idle, input logic [6:0] stall);
    stim_request_t r;
    r = '0;
    r.kind      = ReqPhase;
    r.idle_pct  = idle;
    r.stall_pct = stall;
    pending_requests.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input int lane,
                                 input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("mismatch in result %0d: %s lane %0d expected %h actual %h",
               result_count, field, lane, want, got);
    end
  endtask

  // Stimulus plan and end of run.
  initial begin
    logic [NumLanes-1:0][31:0] th;
    logic [6:0] idle_pcts [4];
    logic [6:0] stall_pcts [4];
    idle_pcts  = '{7'd0, 7'd58, 7'd0, 7'd29};
    stall_pcts = '{7'd0, 7'd0, 7'd58, 7'd29};

    push_phase(7'd0, 7'd0);
    push_group({NumLanes{32'h0}}, '0);
    push_group({NumLanes{32'hffff_ffff}}, '1);
    // Zero seed written mid-frame: the current frame finishes on the old seed,
    // then lane 0 sits at zero for the whole next frame.
    push_seed(32'h0);
    push_group({32'h8000_0000, 32'hffff_ffff, 32'h1, 32'h0}, 4'b1010);
    push_group({32'h7fff_ffff, 32'h1, 32'h0, 32'hffff_ffff}, 4'b0101);
    push_group({NumLanes{32'h0}}, '1);
    push_group({NumLanes{32'h1}}, '0);
    push_group({NumLanes{32'hffff_ffff}}, 4'b1100);
    push_group({NumLanes{32'h0}}, 4'b0011);
    push_seed(32'hffff_ffff);
    for (int i = 0; i < 4; i++) begin
      th = {$urandom, $urandom, $urandom, $urandom};
      push_group(th, 4'($urandom));
    end
    // This seed makes lane 1 start from zero.
    push_seed(GoldenMix);
    for (int i = 0; i < 4; i++) begin
      push_group({32'h0, 32'h1, 32'h0, $urandom}, 4'($urandom));
    end
    push_seed(SeedAtReset);
    push_group({NumLanes{32'hffff_ffff}}, 4'b0110);
    push_group({NumLanes{32'h0}}, 4'b1001);

    for (int p = 0; p < 4; p++) begin
      push_phase(idle_pcts[p], stall_pcts[p]);
      for (int i = 0; i < RandomGroups / 4; i++) begin
        if ($urandom_range(59) == 0) begin
          case ($urandom_range(4))
            0:       push_drain();
            1:       push_seed(32'h0);
            2:       push_seed(32'hffff_ffff);
            default: push_seed($urandom);
          endcase
        end
        for (int l = 0; l < NumLanes; l++) begin
          case ($urandom_range(9))
            0:       th[l] = 32'h0;
            1:       th[l] = 32'hffff_ffff;
            2:       th[l] = $urandom_range(255);
            default: th[l] = $urandom;
          endcase
        end
        push_group(th, 4'($urandom));
      end
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || predicted_groups.size() != 0 || s_axis_tvalid) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles + 5) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_groups.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Input side: requests and seed writes taken at this edge.
  always @(posedge clk_i) begin
    group_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    seed_taken  <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      model_seed = cfg_data_i;
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predicted_groups.push_back(inject_errors(s_axis_tdata));
    end
  end

  always @(negedge clk_i) begin : request_driver
    logic               valid_nxt;
    logic [TdataW-1:0]  data_nxt;
    logic               cfg_valid_nxt;
    logic [31:0]        cfg_data_nxt;
    stim_request_t      head;
    valid_nxt     = s_axis_tvalid && !group_taken;
    data_nxt      = s_axis_tdata;
    cfg_valid_nxt = cfg_valid_i && !seed_taken;
    cfg_data_nxt  = cfg_data_i;
    if (rst_ni && !valid_nxt && !cfg_valid_nxt && pending_requests.size() != 0) begin
      head = pending_requests[0];
      case (head.kind)
        ReqGroup: begin
          if ($urandom_range(99) >= send_idle_pct) begin
            data_nxt = '0;
            for (int l = 0; l < NumLanes; l++) begin
              data_nxt[l*LaneBits +: LaneBits] = {head.bits[l], head.thresh[l]};
            end
            valid_nxt = 1'b1;
            void'(pending_requests.pop_front());
          end
        end
        ReqSeed: begin
          cfg_valid_nxt = 1'b1;
          cfg_data_nxt  = head.seed;
          void'(pending_requests.pop_front());
        end
        ReqDrain: begin
          if (predicted_groups.size() == 0) begin
            if (settle_count == SettleCycles) begin
              settle_count = 0;
              void'(pending_requests.pop_front());
            end else begin
              settle_count++;
            end
          end
        end
        default: begin
          send_idle_pct  <= head.idle_pct;
          recv_stall_pct <= head.stall_pct;
          void'(pending_requests.pop_front());
        end
      endcase
    end
    s_axis_tvalid <= valid_nxt;
    s_axis_tdata  <= data_nxt;
    cfg_valid_i   <= cfg_valid_nxt;
    cfg_data_i    <= cfg_data_nxt;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_monitor
    noisy_group_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_groups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports) begin
          $display("unexpected result %0d: tdata %h tlast %b",
                   result_count, m_axis_tdata, m_axis_tlast);
        end
      end else begin
        want = predicted_groups.pop_front();
        for (int l = 0; l < NumLanes; l++) begin
          if (m_axis_tdata[l*LaneBits +: 32] !== want.word[l]) begin
            report_mismatch("random_word", l, want.word[l], m_axis_tdata[l*LaneBits +: 32]);
          end
          if (m_axis_tdata[l*LaneBits+32] !== want.noisy[l]) begin
            report_mismatch("noisy_bit", l, 32'(want.noisy[l]),
                            32'(m_axis_tdata[l*LaneBits+32]));
          end
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch("last_of_frame", 0, 32'(want.last), 32'(m_axis_tlast));
        end
      end
      result_count++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule

@@ files.f @@
rtl/lbei_pkg.sv
rtl/lbei_lane.sv
rtl/lbei_out.sv
rtl/lfsr_bit_error_injector.sv
rtl/lbei_checker.sv
verif/testbench.sv
